// ----- sv/crc8fd_pkg.sv -----
// ----------------------------------------------------------------------------
// crc8fd_pkg
// Shared types, constants and the CRC-8 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package crc8fd_pkg;

    localparam int unsigned MAX_FRAME_LEN = 32;
    localparam int unsigned INDEX_LIMIT   = 32;
    localparam int unsigned EFF_MAX_LEN   =
        (MAX_FRAME_LEN < INDEX_LIMIT) ? MAX_FRAME_LEN : INDEX_LIMIT;
    localparam int unsigned MIN_FRAME_LEN = 5;

    localparam logic [7:0] CRC_POLY       = 8'h8c;
    localparam logic [7:0] BYPASS_CODE    = 8'hff;
    localparam logic [7:0] HEAD_RESET     = 8'h5a;
    localparam logic [7:0] DEV_ID_RESET   = 8'h01;
    localparam logic       BYPASS_RESET   = 1'b1;

    localparam logic [7:0] MIN_LEN_BYTE   = 8'(MIN_FRAME_LEN);
    localparam logic [7:0] MAX_LEN_BYTE   = 8'(EFF_MAX_LEN);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CHECK_ERR = 2'd1,
        ST_WRONG_DEV = 2'd2,
        ST_BAD_LEN   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_HEAD_VALUE   = 2'd0,
        CFG_OWN_DEV_ID   = 2'd1,
        CFG_BYPASS_EN    = 2'd2
    } t_cfg_index;

    // reflected CRC-8, LSB first, one byte
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/crc8_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// crc8_frame_deframer
// Hunts for a head byte, then streams a length-prefixed frame with its byte
// index and ends it with an accept / check / device / length status.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  rx        i_rx_valid / o_rx_stall    i_rx_byte
//  out       o_out_valid / i_out_stall  o_frame_byte, o_byte_index,
//                                       o_frame_end, o_frame_status
//  cfg       i_cfg_we                   i_cfg_index, i_cfg_wdata
//
//  One rx word per cycle while rx is not stalled; each accepted head or
//  frame byte gives a result word, registered in the next cycle. The CRC-8
//  update and frame checks sit between the state and the output register.
//  rx stalls only while the output register is full and stalled.
//  Synchronous active-low reset; resumes hunting with reset config.
// ----------------------------------------------------------------------------
module crc8_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_frame_byte,
    output logic [4:0] o_byte_index,
    output logic       o_frame_end,
    output logic [1:0] o_frame_status,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata
);

    logic [7:0]           r_head, r_dev_id;
    logic                 r_bypass;

    crc8fd_pkg::t_phase   r_phase, n_phase;
    logic [5:0]           r_exp_len, n_exp_len;
    logic [4:0]           r_pos, n_pos;
    logic [7:0]           r_crc, n_crc;
    logic                 r_dev_ok, n_dev_ok;

    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_frame_byte, n_frame_byte;
    logic [4:0]           r_byte_index, n_byte_index;
    logic                 r_frame_end, n_frame_end;
    crc8fd_pkg::t_status  r_status, n_status;

    logic                 accept, emit, check_ok;
    logic [5:0]           pos_next;

    assign o_rx_stall     = r_out_valid & i_out_stall;
    assign accept         = i_rx_valid & ~o_rx_stall;
    assign o_out_valid    = r_out_valid;
    assign o_frame_byte   = r_frame_byte;
    assign o_byte_index   = r_byte_index;
    assign o_frame_end    = r_frame_end;
    assign o_frame_status = r_status;

    assign pos_next = {1'b0, r_pos} + 6'd1;
    assign check_ok = (i_rx_byte == r_crc) ||
                      (r_bypass && (i_rx_byte == crc8fd_pkg::BYPASS_CODE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= crc8fd_pkg::HEAD_RESET;
            r_dev_id <= crc8fd_pkg::DEV_ID_RESET;
            r_bypass <= crc8fd_pkg::BYPASS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crc8fd_pkg::CFG_HEAD_VALUE: r_head   <= i_cfg_wdata;
                crc8fd_pkg::CFG_OWN_DEV_ID: r_dev_id <= i_cfg_wdata;
                crc8fd_pkg::CFG_BYPASS_EN:  r_bypass <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_exp_len    = r_exp_len;
        n_pos        = r_pos;
        n_crc        = r_crc;
        n_dev_ok     = r_dev_ok;
        emit         = 1'b0;
        n_frame_byte = i_rx_byte;
        n_byte_index = r_pos;
        n_frame_end  = 1'b0;
        n_status     = crc8fd_pkg::ST_OK;

        case (r_phase)
            crc8fd_pkg::PH_LEN: begin
                emit         = 1'b1;
                n_byte_index = 5'd1;
                if (i_rx_byte < crc8fd_pkg::MIN_LEN_BYTE ||
                    i_rx_byte > crc8fd_pkg::MAX_LEN_BYTE) begin
                    n_frame_end = 1'b1;
                    n_status    = crc8fd_pkg::ST_BAD_LEN;
                    n_phase     = crc8fd_pkg::PH_HUNT;
                    n_pos       = 5'd0;
                    n_crc       = 8'd0;
                end else begin
                    n_exp_len = i_rx_byte[5:0];
                    n_crc     = crc8fd_pkg::crc8_feed(r_crc, i_rx_byte);
                    n_pos     = 5'd2;
                    n_dev_ok  = 1'b0;
                    n_phase   = crc8fd_pkg::PH_BODY;
                end
            end
            crc8fd_pkg::PH_BODY: begin
                emit = 1'b1;
                if (pos_next >= r_exp_len) begin
                    n_frame_end = 1'b1;
                    if (!check_ok) begin
                        n_status = crc8fd_pkg::ST_CHECK_ERR;
                    end else if (!r_dev_ok) begin
                        n_status = crc8fd_pkg::ST_WRONG_DEV;
                    end
                    n_phase = crc8fd_pkg::PH_HUNT;
                    n_pos   = 5'd0;
                    n_crc   = 8'd0;
                end else begin
                    if (r_pos == 5'd2) begin
                        n_dev_ok = (i_rx_byte == r_dev_id);
                    end
                    n_crc = crc8fd_pkg::crc8_feed(r_crc, i_rx_byte);
                    n_pos = pos_next[4:0];
                end
            end
            default: begin
                n_phase = crc8fd_pkg::PH_HUNT;
                if (i_rx_byte == r_head) begin
                    emit         = 1'b1;
                    n_byte_index = 5'd0;
                    n_crc        = crc8fd_pkg::crc8_feed(8'd0, i_rx_byte);
                    n_pos        = 5'd1;
                    n_dev_ok     = 1'b0;
                    n_exp_len    = 6'd0;
                    n_phase      = crc8fd_pkg::PH_LEN;
                end
            end
        endcase

        if (accept && emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= crc8fd_pkg::PH_HUNT;
            r_exp_len   <= 6'd0;
            r_pos       <= 5'd0;
            r_crc       <= 8'd0;
            r_dev_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_phase   <= n_phase;
                r_exp_len <= n_exp_len;
                r_pos     <= n_pos;
                r_crc     <= n_crc;
                r_dev_ok  <= n_dev_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_frame_byte <= n_frame_byte;
            r_byte_index <= n_byte_index;
            r_frame_end  <= n_frame_end;
            r_status     <= n_status;
        end
    end

endmodule

// ----- sv/crc8fd_checker.sv -----
// ----------------------------------------------------------------------------
// crc8fd_checker
// Port-level checks on the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module crc8fd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_rx_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_frame_byte,
    input logic [4:0] o_byte_index,
    input logic       o_frame_end,
    input logic [1:0] o_frame_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_byte) &&
            $stable(o_byte_index) && $stable(o_frame_end) && $stable(o_frame_status))
        else $error("stalled output word changed");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_out_valid && i_out_stall)
        else $error("rx stalled without a blocked output word");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_end |-> o_frame_status == crc8fd_pkg::ST_OK)
        else $error("status set on a non-final word");

    a_head_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_index == 5'd0 |-> !o_frame_end)
        else $error("head word marked as frame end");

    a_bad_len_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end && o_frame_status == crc8fd_pkg::ST_BAD_LEN
            |-> o_byte_index == 5'd1)
        else $error("bad length reported away from the length word");

endmodule

bind crc8_frame_deframer crc8fd_checker u_crc8fd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_rx_stall     (o_rx_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_frame_byte   (o_frame_byte),
    .o_byte_index   (o_byte_index),
    .o_frame_end    (o_frame_end),
    .o_frame_status (o_frame_status)
);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crc8_frame_deframer. A clocked driver feeds link
// bytes from a queue with random gaps and predicts each frame word. A clocked
// monitor stalls at random, including repeated long hold-offs, and checks every
// output word against the prediction. Config changes only between phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int          CLK_HALF       = 5;
    localparam int          RESET_CYCLES   = 12;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_LIMIT    = 2000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          PHASE_ITEMS    = 305;
    localparam int          NUM_PHASES     = 6;
    localparam logic [1:0]  CFG_NO_REG     = 2'd3;

    typedef enum {CHK_GOOD, CHK_BYPASS, CHK_BAD} t_check_kind;

    typedef struct packed {
        logic [7:0]          fbyte;
        logic [4:0]          idx;
        logic                last;
        crc8fd_pkg::t_status st;
    } t_frame_word;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] frame_byte;
    logic [4:0] byte_index;
    logic       frame_end;
    logic [1:0] frame_status;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = crc8fd_pkg::CFG_HEAD_VALUE;
    logic [7:0] cfg_wdata = 8'h00;

    // config mirror
    logic [7:0] c_head   = crc8fd_pkg::HEAD_RESET;
    logic [7:0] c_dev    = crc8fd_pkg::DEV_ID_RESET;
    logic       c_bypass = crc8fd_pkg::BYPASS_RESET;

    // deframer state mirror
    crc8fd_pkg::t_phase p_phase  = crc8fd_pkg::PH_HUNT;
    logic [5:0]         p_len    = '0;
    logic [4:0]         p_pos    = '0;
    logic [7:0]         p_crc    = '0;
    logic               p_dev_ok = 1'b0;

    logic [7:0]  link_bytes[$];
    t_frame_word frame_words_due[$];
    t_frame_word due_word;

    int  mismatches     = 0;
    int  words_out      = 0;
    int  tx_gap         = 0;
    int  stall_left     = 0;
    int  next_long_hold = 400;
    bit  calm           = 1'b0;

    crc8_frame_deframer u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_frame_byte   (frame_byte),
        .o_byte_index   (byte_index),
        .o_frame_end    (frame_end),
        .o_frame_status (frame_status),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ crc8fd_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic push_word(input logic [7:0] b, input logic [4:0] idx,
                             input logic last, input crc8fd_pkg::t_status st);
        t_frame_word w;
        w.fbyte = b;
        w.idx   = idx;
        w.last  = last;
        w.st    = st;
        frame_words_due.push_back(w);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic ok;
        case (p_phase)
            crc8fd_pkg::PH_LEN: begin
                if (b < crc8fd_pkg::MIN_LEN_BYTE || b > crc8fd_pkg::MAX_LEN_BYTE) begin
                    push_word(b, 5'd1, 1'b1, crc8fd_pkg::ST_BAD_LEN);
                    p_phase = crc8fd_pkg::PH_HUNT;
                    p_pos   = '0;
                    p_crc   = '0;
                end else begin
                    p_len    = b[5:0];
                    p_crc    = crc8_next(p_crc, b);
                    p_pos    = 5'd2;
                    p_dev_ok = 1'b0;
                    p_phase  = crc8fd_pkg::PH_BODY;
                    push_word(b, 5'd1, 1'b0, crc8fd_pkg::ST_OK);
                end
            end
            crc8fd_pkg::PH_BODY: begin
                if (int'(p_pos) + 1 >= int'(p_len)) begin
                    ok = (b == p_crc) || (c_bypass && b == crc8fd_pkg::BYPASS_CODE);
                    push_word(b, p_pos, 1'b1,
                              !ok ? crc8fd_pkg::ST_CHECK_ERR :
                              (p_dev_ok ? crc8fd_pkg::ST_OK : crc8fd_pkg::ST_WRONG_DEV));
                    p_phase = crc8fd_pkg::PH_HUNT;
                    p_pos   = '0;
                    p_crc   = '0;
                end else begin
                    if (p_pos == 5'd2) begin
                        p_dev_ok = (b == c_dev);
                    end
                    p_crc = crc8_next(p_crc, b);
                    push_word(b, p_pos, 1'b0, crc8fd_pkg::ST_OK);
                    p_pos = p_pos + 5'd1;
                end
            end
            default: begin
                if (b == c_head) begin
                    p_crc    = crc8_next(8'h00, b);
                    p_pos    = 5'd1;
                    p_dev_ok = 1'b0;
                    p_len    = '0;
                    p_phase  = crc8fd_pkg::PH_LEN;
                    push_word(b, 5'd0, 1'b0, crc8fd_pkg::ST_OK);
                end else begin
                    p_phase = crc8fd_pkg::PH_HUNT;
                end
            end
        endcase
    endtask

    // link driver
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (rx_valid && !rx_stall) begin
                deframe_byte(rx_byte);
            end
            if (!rx_valid || !rx_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    rx_valid <= 1'b0;
                end else if (link_bytes.size() > 0) begin
                    rx_byte  <= link_bytes.pop_front();
                    rx_valid <= 1'b1;
                    tx_gap = gap_len();
                end else begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                words_out++;
                if (frame_words_due.size() == 0) begin
                    report_mismatch("word with nothing due, byte", frame_byte, 0);
                end else begin
                    due_word = frame_words_due.pop_front();
                    if (frame_byte !== due_word.fbyte)
                        report_mismatch("frame_byte", frame_byte, due_word.fbyte);
                    if (byte_index !== due_word.idx)
                        report_mismatch("byte_index", byte_index, due_word.idx);
                    if (frame_end !== due_word.last)
                        report_mismatch("frame_end", frame_end, due_word.last);
                    if (frame_status !== due_word.st)
                        report_mismatch("frame_status", frame_status, due_word.st);
                end
            end
            if (words_out >= next_long_hold) begin
                // long hold-off so the block backs up into the link side
                stall_left = $urandom_range(150, 300);
                next_long_hold = next_long_hold + $urandom_range(600, 800);
            end else if (stall_left == 0) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((rx_valid && !rx_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb NOT OK");
        $finish;
    end

    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            crc8fd_pkg::CFG_HEAD_VALUE: c_head   = data;
            crc8fd_pkg::CFG_OWN_DEV_ID: c_dev    = data;
            crc8fd_pkg::CFG_BYPASS_EN:  c_bypass = data[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        int n;
        while (link_bytes.size() != 0 || rx_valid) @(posedge clk);
        n = 0;
        while (frame_words_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        if (frame_words_due.size() != 0) begin
            report_mismatch("words never delivered", 0, frame_words_due.size());
            frame_words_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_frame(input int len, input logic [7:0] dev, input logic [7:0] cmd,
                             input t_check_kind kind);
        logic [7:0] crc;
        logic [7:0] b;
        crc = 8'h00;
        for (int i = 0; i < len - 1; i++) begin
            case (i)
                0:       b = c_head;
                1:       b = 8'(len);
                2:       b = dev;
                3:       b = cmd;
                default: b = 8'($urandom);
            endcase
            link_bytes.push_back(b);
            crc = crc8_next(crc, b);
        end
        case (kind)
            CHK_GOOD:   link_bytes.push_back(crc);
            CHK_BYPASS: link_bytes.push_back(crc8fd_pkg::BYPASS_CODE);
            default:    link_bytes.push_back(crc ^ 8'($urandom_range(1, 255)));
        endcase
    endtask

    task automatic gen_traffic(input int n_items);
        int count;
        int r;
        int len;
        int k;
        logic [7:0] dev;
        t_check_kind kind;
        count = 0;
        while (count < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = ($urandom_range(0, 9) == 0) ?
                      $urandom_range(crc8fd_pkg::MIN_FRAME_LEN, crc8fd_pkg::EFF_MAX_LEN) :
                      $urandom_range(crc8fd_pkg::MIN_FRAME_LEN, 10);
                dev = ($urandom_range(0, 4) == 0) ? 8'($urandom) : c_dev;
                k = $urandom_range(0, 19);
                kind = (k < 15) ? CHK_GOOD : ((k < 17) ? CHK_BYPASS : CHK_BAD);
                add_frame(len, dev, 8'($urandom), kind);
                count += len;
            end else if (r < 80) begin
                link_bytes.push_back(c_head);
                if ($urandom_range(0, 1) == 0)
                    link_bytes.push_back(8'($urandom_range(0, crc8fd_pkg::MIN_FRAME_LEN - 1)));
                else
                    link_bytes.push_back(
                        8'($urandom_range(crc8fd_pkg::EFF_MAX_LEN + 1, 255)));
                count += 2;
            end else if (r < 90) begin
                k = $urandom_range(1, 6);
                repeat (k) link_bytes.push_back(8'($urandom));
                count += k;
            end else begin
                // cut-off frame; whatever follows completes it
                len = $urandom_range(crc8fd_pkg::MIN_FRAME_LEN, 12);
                link_bytes.push_back(c_head);
                link_bytes.push_back(8'(len));
                k = $urandom_range(1, len - 3);
                repeat (k) link_bytes.push_back(8'($urandom));
                count += k + 2;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: noise, good frame with head value as command,
        // bad lengths, check and device both wrong, bypass byte
        link_bytes.push_back(8'h00);
        link_bytes.push_back(8'hff);
        add_frame(crc8fd_pkg::MIN_FRAME_LEN, c_dev, c_head, CHK_GOOD);
        link_bytes.push_back(c_head);
        link_bytes.push_back(crc8fd_pkg::MIN_LEN_BYTE - 8'd1);
        link_bytes.push_back(c_head);
        link_bytes.push_back(8'h00);
        link_bytes.push_back(c_head);
        link_bytes.push_back(crc8fd_pkg::MAX_LEN_BYTE + 8'd1);
        link_bytes.push_back(c_head);
        link_bytes.push_back(8'hff);
        add_frame(crc8fd_pkg::MIN_FRAME_LEN, c_dev + 8'd1, 8'h00, CHK_BAD);
        add_frame(crc8fd_pkg::MIN_FRAME_LEN, c_dev, 8'h00, CHK_BYPASS);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_cfg(crc8fd_pkg::CFG_HEAD_VALUE, 8'h00);
                    write_cfg(crc8fd_pkg::CFG_OWN_DEV_ID, 8'h00);
                    write_cfg(crc8fd_pkg::CFG_BYPASS_EN, 8'hfe);
                end
                1: begin
                    write_cfg(crc8fd_pkg::CFG_HEAD_VALUE, 8'hff);
                    write_cfg(crc8fd_pkg::CFG_OWN_DEV_ID, 8'hff);
                    write_cfg(crc8fd_pkg::CFG_BYPASS_EN, 8'h01);
                end
                default: begin
                    write_cfg(CFG_NO_REG, 8'($urandom));
                    write_cfg(crc8fd_pkg::CFG_HEAD_VALUE, 8'($urandom));
                    write_cfg(crc8fd_pkg::CFG_OWN_DEV_ID, 8'($urandom));
                    write_cfg(crc8fd_pkg::CFG_BYPASS_EN, 8'($urandom));
                end
            endcase
            calm = (ph % 3 == 2);
            gen_traffic(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/crc8fd_pkg.sv
sv/crc8_frame_deframer.sv
sv/crc8fd_checker.sv
sim/tb.sv
